// ===== src/esl_pkg.sv =====
// ----------------------------------------------------------------------------
// esl_pkg
// Shared types, codes and small lookup functions of the event stream lexer.
// ----------------------------------------------------------------------------
package esl_pkg;

    localparam int ByteW  = 8;
    localparam int RetryW = 64;

    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChColon = 8'h3A;
    localparam logic [ByteW-1:0] ChSpace = 8'h20;
    localparam logic [ByteW-1:0] ChZero  = 8'h30;
    localparam logic [ByteW-1:0] ChNine  = 8'h39;
    localparam logic [ByteW-1:0] ChNul   = 8'h00;

    // Token codes on the result channel
    typedef enum logic [3:0] {
        KIND_DATA_BYTE  = 4'd0,
        KIND_DATA_SEP   = 4'd1,
        KIND_TYPE_CLEAR = 4'd2,
        KIND_TYPE_BYTE  = 4'd3,
        KIND_ID_BYTE    = 4'd4,
        KIND_ID_COMMIT  = 4'd5,
        KIND_ID_DISCARD = 4'd6,
        KIND_RETRY      = 4'd7,
        KIND_DISPATCH   = 4'd8,
        KIND_EMPTY_DISP = 4'd9
    } t_kind;

    // Position within the current line
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_NAME    = 3'd1,
        PH_COMMENT = 3'd2,
        PH_VSTART  = 3'd3,
        PH_VALUE   = 3'd4,
        PH_IGNORE  = 3'd5
    } t_phase;

    // Field selected by the line's name; FLD_NONE when nothing matches
    typedef enum logic [2:0] {
        FLD_DATA  = 3'd0,
        FLD_EVENT = 3'd1,
        FLD_ID    = 3'd2,
        FLD_RETRY = 3'd3,
        FLD_NONE  = 3'd4
    } t_field;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [ByteW-1:0]   data;
        logic [RetryW-1:0]  ms;
    } t_token;

    // Byte-order mark bytes in order
    function automatic logic [ByteW-1:0] mark_byte(input logic [1:0] pos);
        logic [ByteW-1:0] v;
        unique case (pos)
            2'd0:    v = 8'hEF;
            2'd1:    v = 8'hBB;
            default: v = 8'hBF;
        endcase
        return v;
    endfunction

    // Character of a field name at a position; zero past its end
    function automatic logic [ByteW-1:0] name_char(input logic [1:0] fld,
                                                  input logic [2:0] idx);
        logic [ByteW-1:0] v;
        v = 8'h00;
        unique case (fld)
            2'd0: begin
                unique case (idx)
                    3'd0: v = 8'h64; 3'd1: v = 8'h61; 3'd2: v = 8'h74; 3'd3: v = 8'h61;
                    default: v = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (idx)
                    3'd0: v = 8'h65; 3'd1: v = 8'h76; 3'd2: v = 8'h65; 3'd3: v = 8'h6E;
                    3'd4: v = 8'h74;
                    default: v = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (idx)
                    3'd0: v = 8'h69; 3'd1: v = 8'h64;
                    default: v = 8'h00;
                endcase
            end
            default: begin
                unique case (idx)
                    3'd0: v = 8'h72; 3'd1: v = 8'h65; 3'd2: v = 8'h74; 3'd3: v = 8'h72;
                    3'd4: v = 8'h79;
                    default: v = 8'h00;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [2:0] name_size(input logic [1:0] fld);
        logic [2:0] v;
        unique case (fld)
            2'd0:    v = 3'd4;
            2'd1:    v = 3'd5;
            2'd2:    v = 3'd2;
            default: v = 3'd5;
        endcase
        return v;
    endfunction

    // Drop candidates that the next name byte does not continue
    function automatic logic [3:0] name_step(input logic [3:0]       hits,
                                             input logic [2:0]       len,
                                             input logic [ByteW-1:0] b);
        logic [3:0] v;
        v = hits;
        for (int i = 0; i < 4; i++) begin
            if (len >= name_size(2'(i)) || name_char(2'(i), len) != b) begin
                v[i] = 1'b0;
            end
        end
        return v;
    endfunction

    // First candidate still alive whose length equals the name length
    function automatic t_field matched_field(input logic [3:0] hits,
                                             input logic [2:0] len);
        t_field v;
        v = FLD_NONE;
        for (int i = 3; i >= 0; i--) begin
            if (hits[i] && len == name_size(2'(i))) begin
                v = t_field'(3'(i));
            end
        end
        return v;
    endfunction

endpackage

// ===== src/event_stream_lexer.sv =====
// ----------------------------------------------------------------------------
// event_stream_lexer
// Byte-serial server-sent-events lexer emitting at most one token per byte.
// Path: an accepted byte is held in the input register, then its token is loaded into the result register.
// Throughput: one byte per cycle; the per-byte update is a single pass.
// Stall: the input stalls only while a token is held and the consumer waits.
// Reset: synchronous, active low; clears lexer state and the valid flags of both registers.
// ----------------------------------------------------------------------------
module event_stream_lexer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [esl_pkg::ByteW-1:0]   i_in_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [3:0]                  o_kind,
    output logic [esl_pkg::ByteW-1:0]   o_out_byte,
    output logic [esl_pkg::RetryW-1:0]  o_retry_ms
);
    import esl_pkg::*;

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    t_token           token;
    logic             can_take;
    logic             step;

    // Process the held byte when its token, if any, has room
    assign step    = r_in_valid && (!token.valid || can_take);
    assign o_ready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    esl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_token (token)
    );

    esl_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && token.valid),
        .i_token    (token),
        .o_can_take (can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_retry_ms (o_retry_ms)
    );

endmodule

// ===== src/esl_core.sv =====
// ----------------------------------------------------------------------------
// esl_core
// Lexer state and the single-pass per-byte update: mark strip, line ends,
// name match, value handling and token selection.
// ----------------------------------------------------------------------------
module esl_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [esl_pkg::ByteW-1:0]  i_byte,
    output esl_pkg::t_token            o_token
);
    import esl_pkg::*;

    logic [1:0]        r_mark_pos,   n_mark_pos;
    logic              r_mark_done,  n_mark_done;
    logic              r_drop_lf,    n_drop_lf;
    t_phase            r_phase,      n_phase;
    logic [3:0]        r_hits,       n_hits;
    logic [2:0]        r_name_len,   n_name_len;
    logic [1:0]        r_field_sel,  n_field_sel;
    logic              r_have_data,  n_have_data;
    logic              r_id_nul,     n_id_nul;
    logic [RetryW-1:0] r_retry_acc,  n_retry_acc;
    logic              r_retry_good, n_retry_good;

    logic              consumed;
    t_phase            phase_eff;
    t_field            fld_end;
    t_field            fld_open;
    logic              is_digit;
    logic [RetryW+3:0] retry_sum;

    // Retry accumulate: acc * 10 + digit as shift-add, carry out means overflow
    always_comb begin
        is_digit  = (i_byte >= ChZero) && (i_byte <= ChNine);
        retry_sum = {1'b0, r_retry_acc, 3'b000} + {3'b000, r_retry_acc, 1'b0}
                  + {{RetryW{1'b0}}, i_byte[3:0] - ChZero[3:0]};
        fld_end   = matched_field(r_hits, r_name_len);
        fld_open  = fld_end;
    end

    // Next state and token for the byte in the input register
    always_comb begin
        n_mark_pos   = r_mark_pos;
        n_mark_done  = r_mark_done;
        n_drop_lf    = r_drop_lf;
        n_phase      = r_phase;
        n_hits       = r_hits;
        n_name_len   = r_name_len;
        n_field_sel  = r_field_sel;
        n_have_data  = r_have_data;
        n_id_nul     = r_id_nul;
        n_retry_acc  = r_retry_acc;
        n_retry_good = r_retry_good;
        o_token      = '{valid: 1'b0, kind: KIND_DATA_BYTE, data: '0, ms: '0};
        consumed     = 1'b0;
        phase_eff    = r_phase;

        // Strip a leading byte-order mark; a broken one spoils the first line
        if (!r_mark_done) begin
            if (r_mark_pos != 2'd3 && i_byte == mark_byte(r_mark_pos)) begin
                consumed = 1'b1;
                if (r_mark_pos == 2'd2) begin
                    n_mark_done = 1'b1;
                    n_mark_pos  = 2'd0;
                end else begin
                    n_mark_pos = r_mark_pos + 2'd1;
                end
            end else begin
                n_mark_done = 1'b1;
                n_mark_pos  = 2'd0;
                if (r_mark_pos != 2'd0) begin
                    phase_eff = PH_IGNORE;
                    n_phase   = PH_IGNORE;
                end
            end
        end

        // Swallow the LF of a CRLF pair
        if (!consumed && r_drop_lf) begin
            n_drop_lf = 1'b0;
            if (i_byte == ChLf) begin
                consumed = 1'b1;
            end
        end

        if (!consumed) begin
            if (i_byte == ChLf || i_byte == ChCr) begin
                // Line end: close whatever the line held
                if (i_byte == ChCr) begin
                    n_drop_lf = 1'b1;
                end
                n_phase = PH_START;
                priority case (phase_eff)
                    PH_START: begin
                        o_token.valid = 1'b1;
                        if (r_have_data) begin
                            n_have_data  = 1'b0;
                            o_token.kind = KIND_DISPATCH;
                        end else begin
                            o_token.kind = KIND_EMPTY_DISP;
                        end
                    end
                    PH_NAME: begin
                        priority case (fld_end)
                            FLD_DATA: begin
                                n_have_data   = 1'b1;
                                o_token.valid = r_have_data;
                                o_token.kind  = KIND_DATA_SEP;
                            end
                            FLD_EVENT: begin
                                o_token.valid = 1'b1;
                                o_token.kind  = KIND_TYPE_CLEAR;
                            end
                            FLD_ID: begin
                                o_token.valid = 1'b1;
                                o_token.kind  = KIND_ID_COMMIT;
                            end
                            default: ;
                        endcase
                    end
                    PH_VSTART, PH_VALUE: begin
                        if (r_field_sel == FLD_ID[1:0]) begin
                            o_token.valid = 1'b1;
                            o_token.kind  = r_id_nul ? KIND_ID_DISCARD : KIND_ID_COMMIT;
                        end else if (r_field_sel == FLD_RETRY[1:0] && r_retry_good) begin
                            o_token.valid = 1'b1;
                            o_token.kind  = KIND_RETRY;
                            o_token.ms    = r_retry_acc;
                        end
                    end
                    default: ;
                endcase
            end else begin
                priority case (phase_eff)
                    PH_START: begin
                        if (i_byte == ChColon) begin
                            n_phase = PH_COMMENT;
                        end else begin
                            n_phase    = PH_NAME;
                            n_hits     = name_step(4'hF, 3'd0, i_byte);
                            n_name_len = 3'd1;
                        end
                    end
                    PH_NAME: begin
                        if (i_byte == ChColon) begin
                            // Open the value of the matched field
                            if (fld_open == FLD_NONE) begin
                                n_phase = PH_IGNORE;
                            end else begin
                                n_field_sel = fld_open[1:0];
                                n_phase     = PH_VSTART;
                                priority case (fld_open)
                                    FLD_DATA: begin
                                        n_have_data   = 1'b1;
                                        o_token.valid = r_have_data;
                                        o_token.kind  = KIND_DATA_SEP;
                                    end
                                    FLD_EVENT: begin
                                        o_token.valid = 1'b1;
                                        o_token.kind  = KIND_TYPE_CLEAR;
                                    end
                                    FLD_ID: begin
                                        n_id_nul = 1'b0;
                                    end
                                    default: begin
                                        n_retry_acc  = '0;
                                        n_retry_good = 1'b0;
                                    end
                                endcase
                            end
                        end else begin
                            n_hits = name_step(r_hits, r_name_len, i_byte);
                            if (r_name_len != 3'd7) begin
                                n_name_len = r_name_len + 3'd1;
                            end
                        end
                    end
                    PH_VSTART, PH_VALUE: begin
                        n_phase = PH_VALUE;
                        // Skip one space right after the colon
                        if (!(phase_eff == PH_VSTART && i_byte == ChSpace)) begin
                            unique case (r_field_sel)
                                2'd0: begin
                                    o_token.valid = 1'b1;
                                    o_token.kind  = KIND_DATA_BYTE;
                                    o_token.data  = i_byte;
                                end
                                2'd1: begin
                                    o_token.valid = 1'b1;
                                    o_token.kind  = KIND_TYPE_BYTE;
                                    o_token.data  = i_byte;
                                end
                                2'd2: begin
                                    if (i_byte == ChNul) begin
                                        n_id_nul = 1'b1;
                                    end
                                    o_token.valid = 1'b1;
                                    o_token.kind  = KIND_ID_BYTE;
                                    o_token.data  = i_byte;
                                end
                                default: begin
                                    if (is_digit && retry_sum[RetryW+3:RetryW] == 4'd0) begin
                                        n_retry_acc  = retry_sum[RetryW-1:0];
                                        n_retry_good = 1'b1;
                                    end else begin
                                        n_phase = PH_IGNORE;
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Advance state when the byte leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_pos   <= 2'd0;
            r_mark_done  <= 1'b0;
            r_drop_lf    <= 1'b0;
            r_phase      <= PH_START;
            r_hits       <= 4'hF;
            r_name_len   <= 3'd0;
            r_field_sel  <= 2'd0;
            r_have_data  <= 1'b0;
            r_id_nul     <= 1'b0;
            r_retry_acc  <= '0;
            r_retry_good <= 1'b0;
        end else if (i_step) begin
            r_mark_pos   <= n_mark_pos;
            r_mark_done  <= n_mark_done;
            r_drop_lf    <= n_drop_lf;
            r_phase      <= n_phase;
            r_hits       <= n_hits;
            r_name_len   <= n_name_len;
            r_field_sel  <= n_field_sel;
            r_have_data  <= n_have_data;
            r_id_nul     <= n_id_nul;
            r_retry_acc  <= n_retry_acc;
            r_retry_good <= n_retry_good;
        end
    end

endmodule

// ===== src/esl_out_reg.sv =====
// ----------------------------------------------------------------------------
// esl_out_reg
// Result register: holds one token request until the consumer takes it.
// ----------------------------------------------------------------------------
module esl_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  esl_pkg::t_token             i_token,
    output logic                        o_can_take,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [3:0]                  o_kind,
    output logic [esl_pkg::ByteW-1:0]   o_out_byte,
    output logic [esl_pkg::RetryW-1:0]  o_retry_ms
);
    import esl_pkg::*;

    logic              r_valid;
    t_kind             r_kind;
    logic [ByteW-1:0]  r_byte;
    logic [RetryW-1:0] r_ms;

    // Free when empty or when the held request leaves this cycle
    assign o_can_take = !r_valid || i_ready;

    // Hold the request flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    // Capture payload on load
    always_ff @(posedge i_clk) begin
        if (o_can_take && i_load) begin
            r_kind <= i_token.kind;
            r_byte <= i_token.data;
            r_ms   <= i_token.ms;
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_out_byte = r_byte;
    assign o_retry_ms = r_ms;

endmodule

// ===== tb/sv/event_stream_lexer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_stream_lexer_test
// Drives raw event-stream bytes into the lexer through the request handshake
// and checks every token against a cycle-free model of the lexer kept here.
// A short directed stream is followed by random, mostly well-formed lines.
// ----------------------------------------------------------------------------
module event_stream_lexer_test;
    import esl_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 4;
    localparam int ITEM_TARGET  = 1500;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 200;

    localparam logic [ByteW-1:0] BOM_0 = 8'hEF;
    localparam logic [ByteW-1:0] BOM_1 = 8'hBB;
    localparam logic [ByteW-1:0] BOM_2 = 8'hBF;

    typedef struct {
        t_kind             kind;
        logic [ByteW-1:0]  val;
        logic [RetryW-1:0] ms;
    } t_exp_token;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_COMB
    } t_rx_mode;

    // Lexer model and the tokens it still owes
    class token_scoreboard;
        t_exp_token        expected_tokens[$];
        int unsigned       errors;
        string             field_names[4];
        int                bom_idx;
        bit                bom_seen;
        bit                swallow_lf;
        t_phase            phase;
        logic [3:0]        cand;
        logic [2:0]        name_count;
        t_field            field;
        bit                data_open;
        bit                id_nul;
        logic [RetryW-1:0] retry_val;
        bit                retry_ok;

        function new();
            field_names = '{"data", "event", "id", "retry"};
            errors      = 0;
            bom_idx     = 0;
            bom_seen    = 1'b0;
            swallow_lf  = 1'b0;
            phase       = PH_START;
            cand        = 4'hF;
            name_count  = '0;
            field       = FLD_DATA;
            data_open   = 1'b0;
            id_nul      = 1'b0;
            retry_val   = '0;
            retry_ok    = 1'b0;
        endfunction

        function void push_token(t_kind k, logic [ByteW-1:0] v = '0,
                                 logic [RetryW-1:0] ms = '0);
            t_exp_token tok;
            tok = '{k, v, ms};
            expected_tokens.insert(expected_tokens.size(), tok);
        endfunction

        // First live candidate whose length equals the name so far
        function t_field pick_field();
            for (int i = 0; i < 4; i++) begin
                if (cand[i] && name_count == field_names[i].len()) begin
                    return t_field'(3'(i));
                end
            end
            return FLD_NONE;
        endfunction

        function void advance_name(logic [ByteW-1:0] b);
            for (int i = 0; i < 4; i++) begin
                if (name_count >= field_names[i].len() || field_names[i][name_count] != b) begin
                    cand[i] = 1'b0;
                end
            end
            if (name_count < 7) begin
                name_count++;
            end
        endfunction

        // Data field opened by a colon or by a bare name
        function void open_data();
            if (data_open) begin
                push_token(KIND_DATA_SEP);
            end
            data_open = 1'b1;
        endfunction

        function void open_field();
            t_field f;
            f = pick_field();
            if (f == FLD_NONE) begin
                phase = PH_IGNORE;
                return;
            end
            field = f;
            phase = PH_VSTART;
            case (f)
                FLD_DATA:  open_data();
                FLD_EVENT: push_token(KIND_TYPE_CLEAR);
                FLD_ID:    id_nul = 1'b0;
                default: begin
                    retry_val = '0;
                    retry_ok  = 1'b0;
                end
            endcase
        endfunction

        function void value_byte(logic [ByteW-1:0] b);
            logic [RetryW-1:0] d;
            case (field)
                FLD_DATA:  push_token(KIND_DATA_BYTE, b);
                FLD_EVENT: push_token(KIND_TYPE_BYTE, b);
                FLD_ID: begin
                    if (b == ChNul) begin
                        id_nul = 1'b1;
                    end
                    push_token(KIND_ID_BYTE, b);
                end
                default: begin
                    // Accumulate decimal digits; drop the line on overflow or junk
                    if (b >= ChZero && b <= ChNine) begin
                        d = RetryW'(b - ChZero);
                        if (retry_val > ({RetryW{1'b1}} - d) / 10) begin
                            phase = PH_IGNORE;
                        end else begin
                            retry_val = retry_val * 10 + d;
                            retry_ok  = 1'b1;
                        end
                    end else begin
                        phase = PH_IGNORE;
                    end
                end
            endcase
        endfunction

        function void end_line();
            case (phase)
                PH_START: begin
                    if (data_open) begin
                        data_open = 1'b0;
                        push_token(KIND_DISPATCH);
                    end else begin
                        push_token(KIND_EMPTY_DISP);
                    end
                end
                PH_NAME: begin
                    case (pick_field())
                        FLD_DATA:  open_data();
                        FLD_EVENT: push_token(KIND_TYPE_CLEAR);
                        FLD_ID:    push_token(KIND_ID_COMMIT);
                        default: ;
                    endcase
                end
                PH_VSTART, PH_VALUE: begin
                    if (field == FLD_ID) begin
                        if (id_nul) begin
                            push_token(KIND_ID_DISCARD);
                        end else begin
                            push_token(KIND_ID_COMMIT);
                        end
                    end else if (field == FLD_RETRY && retry_ok) begin
                        push_token(KIND_RETRY, '0, retry_val);
                    end
                end
                default: ;
            endcase
        endfunction

        function logic [ByteW-1:0] bom_byte(int idx);
            case (idx)
                0:       return BOM_0;
                1:       return BOM_1;
                default: return BOM_2;
            endcase
        endfunction

        // Advance the model by one accepted request
        function void note_byte(logic [ByteW-1:0] b);
            if (!bom_seen) begin
                if (bom_idx < 3 && b == bom_byte(bom_idx)) begin
                    bom_idx++;
                    if (bom_idx >= 3) begin
                        bom_seen = 1'b1;
                        bom_idx  = 0;
                    end
                    return;
                end
                // A broken mark turns its line into an unknown one
                bom_seen = 1'b1;
                if (bom_idx != 0) begin
                    phase = PH_IGNORE;
                end
                bom_idx = 0;
            end
            if (swallow_lf) begin
                swallow_lf = 1'b0;
                if (b == ChLf) begin
                    return;
                end
            end
            if (b == ChLf || b == ChCr) begin
                swallow_lf = (b == ChCr);
                end_line();
                phase = PH_START;
                return;
            end
            case (phase)
                PH_START: begin
                    if (b == ChColon) begin
                        phase = PH_COMMENT;
                    end else begin
                        phase      = PH_NAME;
                        cand       = 4'hF;
                        name_count = '0;
                        advance_name(b);
                    end
                end
                PH_NAME: begin
                    if (b == ChColon) begin
                        open_field();
                    end else begin
                        advance_name(b);
                    end
                end
                PH_VSTART: begin
                    phase = PH_VALUE;
                    if (b != ChSpace) begin
                        value_byte(b);
                    end
                end
                PH_VALUE: value_byte(b);
                default: ;
            endcase
        endfunction

        // Compare one accepted token with the oldest one owed
        function void check_token(logic [3:0] kind, logic [ByteW-1:0] val,
                                  logic [RetryW-1:0] ms);
            t_exp_token want;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: token with none expected: kind %0d byte %h retry %0d",
                             $time, kind, val, ms);
                end
                return;
            end
            want = expected_tokens[0];
            expected_tokens.delete(0);
            if (kind !== want.kind) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: kind: expected %0d, actual %0d", $time, want.kind, kind);
                end
            end
            if (val !== want.val) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: out_byte: expected %h, actual %h", $time, want.val, val);
                end
            end
            if (ms !== want.ms) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: retry_ms: expected %0d, actual %0d", $time, want.ms, ms);
                end
            end
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic [ByteW-1:0]  i_in_byte  = '0;
    logic              i_ready    = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [3:0]        o_kind;
    logic [ByteW-1:0]  o_out_byte;
    logic [RetryW-1:0] o_retry_ms;

    token_scoreboard scoreboard = new();

    int       burst_left    = 0;
    int       counted_bytes = 0;
    int       cycle_count   = 0;
    t_rx_mode rx_mode       = RX_OPEN;
    int       rx_left       = 0;
    int       rx_tick       = 0;
    string    odd_names[9]  = '{"dat", "datas", "Data", "events", "i", "ids",
                                "retr", "retryx", "x"};

    event_stream_lexer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_retry_ms (o_retry_ms)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("event_stream_lexer_test: errors");
            $finish;
        end
    end

    // Stall the token side on a changing pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN: i_ready <= 1'b1;
            RX_COIN: i_ready <= 1'($urandom_range(0, 1));
            RX_SLOW: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= ((rx_tick % 7) < 3);
        endcase
    end

    // Check each accepted token
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            scoreboard.check_token(o_kind, o_out_byte, o_retry_ms);
        end
    end

    // Present one request and hold it until taken; entered and left at a falling edge
    task automatic send_byte(input logic [ByteW-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scoreboard.note_byte(b);
        counted_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // End the line with LF, CR or CRLF
    task automatic send_eol();
        case ($urandom_range(0, 2))
            0: send_byte(ChLf);
            1: send_byte(ChCr);
            default: begin
                send_byte(ChCr);
                send_byte(ChLf);
            end
        endcase
    endtask

    function automatic logic [ByteW-1:0] content_byte();
        logic [ByteW-1:0] b;
        if ($urandom_range(0, 1) == 1) begin
            b = 8'($urandom_range(8'h20, 8'h7E));
        end else begin
            b = 8'($urandom_range(0, 255));
        end
        if (b == ChLf || b == ChCr) begin
            b = ChSpace;
        end
        return b;
    endfunction

    task automatic send_content(input int n);
        repeat (n) send_byte(content_byte());
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_byte(ChZero + 8'($urandom_range(0, 9)));
    endtask

    // Field line with random value, sometimes bare name
    task automatic send_value_line(input string name, input bit with_nul);
        send_text(name);
        if ($urandom_range(0, 9) != 0) begin
            send_byte(ChColon);
            if ($urandom_range(0, 1) == 1) begin
                send_byte(ChSpace);
            end
            send_content($urandom_range(0, 12));
            if (with_nul && $urandom_range(0, 2) == 0) begin
                send_byte(ChNul);
                send_content($urandom_range(0, 4));
            end
        end
        send_eol();
    endtask

    task automatic send_retry_line();
        logic [ByteW-1:0] junk;
        send_text("retry");
        case ($urandom_range(0, 11))
            0: ;
            1: send_byte(ChColon);
            2: send_text(": 18446744073709551615");
            3: send_text(":18446744073709551616");
            4: begin
                send_byte(ChColon);
                send_digits(21);
            end
            5: begin
                junk = content_byte();
                if (junk >= ChZero && junk <= ChNine) begin
                    junk = 8'h2D;
                end
                send_byte(ChColon);
                send_digits($urandom_range(0, 3));
                send_byte(junk);
                send_digits($urandom_range(0, 3));
            end
            6: send_text(":  5");
            default: begin
                send_byte(ChColon);
                if ($urandom_range(0, 1) == 1) begin
                    send_byte(ChSpace);
                end
                send_digits($urandom_range(1, 6));
            end
        endcase
        send_eol();
    endtask

    // Hold off requests until every owed token has come out
    task automatic drain_wait();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (scoreboard.expected_tokens.size() != 0);
    endtask

    initial begin
        int pick;
        int n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Leading mark: none, whole, or broken after one or two bytes
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                send_byte(BOM_0);
                send_byte(BOM_1);
                send_byte(BOM_2);
            end
            2: send_byte(BOM_0);
            default: begin
                send_byte(BOM_0);
                send_byte(BOM_1);
            end
        endcase
        // Id holding a NUL and the top byte, ended by CRLF
        send_text("id:");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ChCr);
        send_byte(ChLf);
        // A second mark is only an unknown name
        send_byte(BOM_0);
        send_byte(BOM_1);
        send_byte(BOM_2);
        send_byte(ChLf);
        send_text(":c");
        send_byte(ChLf);
        send_text("data");
        send_byte(ChLf);
        send_byte(ChLf);
        send_byte(ChCr);
        drain_wait();

        while (counted_bytes < ITEM_TARGET) begin
            if ($urandom_range(0, 149) == 0) begin
                drain_wait();
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_value_line("data", 1'b0);
            end else if (pick < 40) begin
                send_value_line("event", 1'b0);
            end else if (pick < 50) begin
                send_value_line("id", 1'b1);
            end else if (pick < 62) begin
                send_retry_line();
            end else if (pick < 78) begin
                send_eol();
            end else if (pick < 84) begin
                send_byte(ChColon);
                send_content($urandom_range(0, 8));
                send_eol();
            end else if (pick < 92) begin
                // Unknown field names, near misses and random bytes
                if ($urandom_range(0, 2) == 0) begin
                    n = $urandom_range(1, 8);
                    send_content(n);
                end else begin
                    send_text(odd_names[$urandom_range(0, 8)]);
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_byte(ChColon);
                    send_content($urandom_range(0, 6));
                end
                send_eol();
            end else begin
                repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
            end
        end

        i_valid <= 1'b0;
        while (scoreboard.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.expected_tokens.size() == 0) begin
            $display("event_stream_lexer_test: clean");
        end else begin
            $display("event_stream_lexer_test: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/esl_pkg.sv
src/esl_core.sv
src/esl_out_reg.sv
src/event_stream_lexer.sv
tb/sv/event_stream_lexer_test.sv
